// ----- rtl/tfcw_pkg.sv -----
package tfcw_pkg;

    // Input function codes.
    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_BUS   = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    // Failure causes reported with each read attempt.
    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_CRC     = 3'd1;
    localparam logic [2:0] CAUSE_POWERUP = 3'd2;
    localparam logic [2:0] CAUSE_RANGE   = 3'd3;
    localparam logic [2:0] CAUSE_BUS     = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_SEED    = 1'b1;

    localparam int          FRAME_LEN_DEF = 9;
    localparam logic [7:0]  CRC_POLY      = 8'h8C;
    localparam logic [23:0] TIMEOUT_RST   = 24'd5000;
    localparam logic [11:0] SEED_RST      = 12'd400;

    // Reading limits in sixteenths of a degree.
    localparam logic signed [15:0] POWERUP_RAW = 16'sd1360;
    localparam logic signed [15:0] RAW_MIN     = -16'sd880;
    localparam logic signed [15:0] RAW_MAX     = 16'sd2000;

    typedef struct packed {
        logic signed [11:0] held_temp;
        logic               new_sample;
        logic [2:0]         fail_cause;
        logic               fault_trip;
        logic               fault_latched;
    } t_result;

endpackage

// ----- rtl/tfcw_crc8.sv -----
// Reflected CRC-8 update by one byte, least significant bit first.
module tfcw_crc8 (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_byte,
    output logic [7:0] o_crc
);

    always_comb begin
        logic [7:0] c;
        logic [7:0] b;
        c = i_crc;
        b = i_byte;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ b[0]) begin
                c = (c >> 1) ^ tfcw_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
            b = b >> 1;
        end
        o_crc = c;
    end

endmodule

// ----- rtl/temp_frame_check_watchdog.sv -----
// Temperature frame checker with a no-good-reading watchdog. Each input beat carries a
// function code: a frame byte, a millisecond tick, a bus failure or a fault clear. A frame
// of FRAME_LEN bytes is checked with a reflected CRC-8 (polynomial 0x8C); bytes 0 and 1 are
// the signed reading in sixteenths of a degree, low byte first. Only the last byte of a
// frame and a bus failure give a result beat; ticks, clears and other frame bytes give none.
// The block takes one beat every clock cycle while o_stall is low: all the checking and
// state update for a beat is done in the cycle it is accepted, and its result goes to the
// output register, or to the skid register if that is still full. These two entries let
// the block keep accepting while a result waits; o_stall is raised only when both are
// full. Configuration writes are always taken (o_cfg_ready is tied high) and must be made
// while the block is idle; writing seed_temp loads the held temperature at once.
module temp_frame_check_watchdog #(
    parameter int FRAME_LEN = tfcw_pkg::FRAME_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input beats.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_data_byte,
    // Result beats.
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [11:0] o_held_temp,
    output logic               o_new_sample,
    output logic [2:0]         o_fail_cause,
    output logic               o_fault_trip,
    output logic               o_fault_latched,
    // Configuration writes.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam int CW = $clog2(FRAME_LEN);

    // Frame assembly and watchdog state.
    logic [CW-1:0]      r_byte_count, n_byte_count;
    logic [7:0]         r_crc, n_crc;
    logic [15:0]        r_raw, n_raw;
    logic signed [11:0] r_held, n_held;
    // The counter saturates at 2**24, which is already above any timeout.
    logic [24:0]        r_ms, n_ms;
    logic               r_fault, n_fault;
    logic [23:0]        r_timeout;

    // Output stage.
    logic               r_out_valid, r_skid_valid;
    tfcw_pkg::t_result  r_out, r_skid;

    logic               in_take, out_take, cfg_take;
    logic               last_byte, attempt, good;
    logic [2:0]         cause;
    logic [24:0]        ms_after;
    logic               trip;
    logic [7:0]         crc_next;
    tfcw_pkg::t_result  res;

    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid;
    assign o_stall     = r_skid_valid;
    assign in_take     = i_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_stall;

    tfcw_crc8 u_crc (
        .i_crc  (r_crc),
        .i_byte (i_data_byte),
        .o_crc  (crc_next)
    );

    assign last_byte = (r_byte_count == CW'(FRAME_LEN - 1));

    // The reading bytes sit at the start of the frame, so at the last byte the raw word
    // is already complete in its register.
    always_comb begin
        attempt = 1'b0;
        cause   = tfcw_pkg::CAUSE_NONE;
        good    = 1'b0;
        if (i_func == tfcw_pkg::FUNC_BYTE && last_byte) begin
            attempt = 1'b1;
            if (crc_next != 8'd0) begin
                cause = tfcw_pkg::CAUSE_CRC;
            end else if ($signed(r_raw) == tfcw_pkg::POWERUP_RAW) begin
                cause = tfcw_pkg::CAUSE_POWERUP;
            end else if ($signed(r_raw) < tfcw_pkg::RAW_MIN ||
                         $signed(r_raw) > tfcw_pkg::RAW_MAX) begin
                cause = tfcw_pkg::CAUSE_RANGE;
            end else begin
                good = 1'b1;
            end
        end else if (i_func == tfcw_pkg::FUNC_BUS) begin
            attempt = 1'b1;
            cause   = tfcw_pkg::CAUSE_BUS;
        end
    end

    // The watchdog looks at the counter as it stands after a good frame has cleared it.
    assign ms_after = good ? 25'd0 : r_ms;
    assign trip     = attempt && !r_fault && (ms_after > {1'b0, r_timeout});

    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_raw        = r_raw;
        n_held       = r_held;
        n_ms         = r_ms;
        n_fault      = r_fault;
        if (in_take) begin
            case (i_func)
                tfcw_pkg::FUNC_BYTE: begin
                    if (last_byte) begin
                        n_byte_count = '0;
                        n_crc        = 8'd0;
                        n_raw        = 16'd0;
                    end else begin
                        n_byte_count = r_byte_count + CW'(1);
                        n_crc        = crc_next;
                        if (r_byte_count == CW'(0)) begin
                            n_raw = {r_raw[15:8], i_data_byte};
                        end else if (r_byte_count == CW'(1)) begin
                            n_raw = {i_data_byte, r_raw[7:0]};
                        end
                    end
                end
                tfcw_pkg::FUNC_TICK: begin
                    if (!r_ms[24]) begin
                        n_ms = r_ms + 25'd1;
                    end
                end
                tfcw_pkg::FUNC_BUS: begin
                    n_byte_count = '0;
                    n_crc        = 8'd0;
                    n_raw        = 16'd0;
                end
                tfcw_pkg::FUNC_CLEAR: begin
                    n_fault = 1'b0;
                end
                default: begin
                end
            endcase
            if (good) begin
                n_held = $signed(r_raw[11:0]);
            end
            n_ms = good ? 25'd0 : n_ms;
            if (trip) begin
                n_fault = 1'b1;
            end
        end
        if (cfg_take && i_cfg_index == tfcw_pkg::CFG_SEED) begin
            n_held = $signed(i_cfg_data[11:0]);
        end
    end

    always_comb begin
        res.held_temp     = n_held;
        res.new_sample    = good;
        res.fail_cause    = cause;
        res.fault_trip    = trip;
        res.fault_latched = r_fault || trip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_crc        <= 8'd0;
            r_raw        <= 16'd0;
            r_held       <= $signed(tfcw_pkg::SEED_RST);
            r_ms         <= 25'd0;
            r_fault      <= 1'b0;
            r_timeout    <= tfcw_pkg::TIMEOUT_RST;
        end else begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_raw        <= n_raw;
            r_held       <= n_held;
            r_ms         <= n_ms;
            r_fault      <= n_fault;
            if (cfg_take && i_cfg_index == tfcw_pkg::CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_take && attempt) begin
            if (!r_out_valid || out_take) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_held_temp     = r_out.held_temp;
    assign o_new_sample    = r_out.new_sample;
    assign o_fail_cause    = r_out.fail_cause;
    assign o_fault_trip    = r_out.fault_trip;
    assign o_fault_latched = r_out.fault_latched;

endmodule

// ----- rtl/tfcw_checker.sv -----
module tfcw_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [11:0] o_held_temp,
    input logic               o_new_sample,
    input logic [2:0]         o_fail_cause,
    input logic               o_fault_trip,
    input logic               o_fault_latched
);

    // The output side comes out of reset empty and not back-pressuring.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

    // Back-pressure is only raised while a result is on offer.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // A good reading never carries a failure cause.
    a_good_no_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_sample |-> o_fail_cause == tfcw_pkg::CAUSE_NONE)
        else $error("good reading reported with a failure cause");

    // A trip on this attempt leaves the latch set.
    a_trip_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fault_trip |-> o_fault_latched)
        else $error("fault tripped but not latched");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_held_temp) && $stable(o_fail_cause))
        else $error("stalled result changed");

endmodule

bind temp_frame_check_watchdog tfcw_checker u_tfcw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_held_temp     (o_held_temp),
    .o_new_sample    (o_new_sample),
    .o_fail_cause    (o_fail_cause),
    .o_fault_trip    (o_fault_trip),
    .o_fault_latched (o_fault_latched)
);
